// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// No dependencies; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed: lbl");

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("assertion failed: lbl");

`endif

// ===== rtl/core/mbe_pkg.sv =====
// Shared constants, codes and types of the escape-time unit.
// No dependencies; used by every module of the block.
`default_nettype none

package mbe_pkg;

  localparam int unsigned COORD_BITS_DEF = 14;
  localparam int unsigned WORD_BITS_DEF  = 36;
  localparam int unsigned FRAC_BITS      = 26;
  localparam int unsigned ACC_W          = 64;  // wide products and sums
  localparam int unsigned MUL_W          = 32;  // multiplier operand width

  localparam int unsigned SIZE_W     = 4;
  localparam int unsigned ITER_W     = 8;
  localparam int unsigned BAIL_W     = 10;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned OUT_W      = 16;

  localparam logic [SIZE_W-1:0] SIZE_LOG2_RST = SIZE_W'(8);
  localparam logic [ITER_W-1:0] MAX_ITER_RST  = ITER_W'(255);
  localparam logic [BAIL_W-1:0] BAILOUT_RST   = BAIL_W'(256);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SIZE_LOG2 = 2'd0,
    REG_MAX_ITER  = 2'd1,
    REG_BAILOUT   = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XX,
    ST_YY,
    ST_XY,
    ST_UPD,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MUL_XX,
    MUL_YY,
    MUL_XY
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     cap_xx;
    logic     cap_yy;
    logic     upd;
    logic     set_esc;
    mul_sel_e mul_sel;
  } dp_ctrl_t;

  typedef struct packed {
    logic rerr_in;
    logic cnt_lim;
    logic mag_esc;
    logic sum_esc;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/mbe_dpath.sv =====
// Datapath: coordinate mapping, shared signed 32x32 multiplier, z registers.
// Depends on mbe_pkg; steered by mbe_ctrl.
`default_nettype none

module mbe_dpath #(
  parameter int unsigned COORD_BITS = mbe_pkg::COORD_BITS_DEF,
  parameter int unsigned WORD_BITS  = mbe_pkg::WORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  mbe_pkg::dp_ctrl_t           ctrl_i,
  input  logic [COORD_BITS-1:0]       row_i,
  input  logic [COORD_BITS-1:0]       col_i,
  input  logic [mbe_pkg::SIZE_W-1:0]  size_log2_i,
  input  logic [mbe_pkg::ITER_W-1:0]  max_iter_i,
  input  logic [mbe_pkg::BAIL_W-1:0]  bailout_i,
  output mbe_pkg::dp_stat_t           stat_o,
  output logic [mbe_pkg::ITER_W-1:0]  count_o,
  output logic                        escaped_o,
  output logic                        range_err_o
);
  import mbe_pkg::*;

  localparam logic signed [ACC_W-1:0] WORD_MAX =
      $signed((ACC_W'(1) << (WORD_BITS - 1)) - ACC_W'(1));
  localparam logic signed [ACC_W-1:0] WORD_MIN = -WORD_MAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] HALF_ONE = $signed(ACC_W'(1) << (FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] MAG_MAX  =
      $signed((ACC_W'(1) << (MUL_W - 1)) - ACC_W'(1));

  function automatic logic signed [WORD_BITS-1:0] sat_word(input logic signed [ACC_W-1:0] v);
    if (v > WORD_MAX) return WORD_MAX[WORD_BITS-1:0];
    if (v < WORD_MIN) return WORD_MIN[WORD_BITS-1:0];
    return v[WORD_BITS-1:0];
  endfunction

  logic signed [WORD_BITS-1:0] x_q, y_q, cr_q, ci_q;
  logic signed [ACC_W-1:0]     xx_q, yy_q, p_q, p_d;
  logic [ITER_W-1:0]           count_q;
  logic                        esc_q, rerr_q;

  logic signed [ACC_W-1:0]     x_ext, y_ext;
  logic signed [MUL_W-1:0]     mul_a, mul_b;
  logic [ACC_W-1:0]            sq_sum, limit;
  logic signed [ACC_W-1:0]     nx_full, ny_full, cr_full, ci_full;
  logic [4:0]                  shamt;
  logic                        inside_all, row_hi, col_hi;

  assign x_ext = ACC_W'(x_q);
  assign y_ext = ACC_W'(y_q);

  // Operands fit 32 bits whenever a product is used: larger |z| escapes first.
  always_comb begin
    unique case (ctrl_i.mul_sel)
      MUL_XX: begin
        mul_a = x_ext[MUL_W-1:0];
        mul_b = x_ext[MUL_W-1:0];
      end
      MUL_YY: begin
        mul_a = y_ext[MUL_W-1:0];
        mul_b = y_ext[MUL_W-1:0];
      end
      MUL_XY: begin
        mul_a = x_ext[MUL_W-1:0];
        mul_b = y_ext[MUL_W-1:0];
      end
      default: begin
        mul_a = x_ext[MUL_W-1:0];
        mul_b = y_ext[MUL_W-1:0];
      end
    endcase
  end

  assign p_d = mul_a * mul_b;

  // |z|^2 test: xx captured last cycle, yy in the product register now
  assign sq_sum = xx_q + p_q;
  assign limit  = ACC_W'(bailout_i) << (2 * FRAC_BITS);

  assign nx_full = (xx_q >>> FRAC_BITS) - (yy_q >>> FRAC_BITS) + ACC_W'(cr_q);
  // floor(2xy / 2^F) == xy >>> (F-1)
  assign ny_full = (p_q >>> (FRAC_BITS - 1)) + ACC_W'(ci_q);

  assign shamt   = 5'(FRAC_BITS) - 5'(size_log2_i);
  assign cr_full = $signed(ACC_W'(row_i) << shamt) - HALF_ONE;
  assign ci_full = $signed(ACC_W'(col_i) << shamt) - HALF_ONE;

  assign inside_all = 32'(size_log2_i) >= COORD_BITS;
  assign row_hi     = (row_i >> size_log2_i) != '0;
  assign col_hi     = (col_i >> size_log2_i) != '0;

  assign stat_o.rerr_in = !inside_all && (row_hi || col_hi);
  assign stat_o.cnt_lim = count_q >= max_iter_i;
  assign stat_o.mag_esc = (x_ext > MAG_MAX) || (x_ext < -MAG_MAX) ||
                          (y_ext > MAG_MAX) || (y_ext < -MAG_MAX);
  assign stat_o.sum_esc = sq_sum >= limit;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    if (ctrl_i.load) begin
      x_q     <= '0;
      y_q     <= '0;
      cr_q    <= sat_word(cr_full);
      ci_q    <= sat_word(ci_full);
      count_q <= '0;
      esc_q   <= 1'b0;
      rerr_q  <= stat_o.rerr_in;
    end
    if (ctrl_i.cap_xx) xx_q <= p_q;
    if (ctrl_i.cap_yy) yy_q <= p_q;
    if (ctrl_i.upd) begin
      x_q     <= sat_word(nx_full);
      y_q     <= sat_word(ny_full);
      count_q <= count_q + ITER_W'(1);
    end
    if (ctrl_i.set_esc) esc_q <= 1'b1;
  end

  assign count_o     = count_q;
  assign escaped_o   = esc_q;
  assign range_err_o = rerr_q;

endmodule

`default_nettype wire

// ===== rtl/core/mbe_ctrl.sv =====
// Sequencer: runs the four-step iteration over the shared multiplier.
// Depends on mbe_pkg; drives mbe_dpath.
`default_nettype none

module mbe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  logic              out_free_i,
  input  mbe_pkg::dp_stat_t stat_i,
  output logic              s_ready_o,
  output logic              emit_o,
  output mbe_pkg::dp_ctrl_t ctrl_o
);
  import mbe_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_valid_i) state_d = stat_i.rerr_in ? ST_DONE : ST_XX;
      ST_XX:   state_d = (stat_i.cnt_lim || stat_i.mag_esc) ? ST_DONE : ST_YY;
      ST_YY:   state_d = ST_XY;
      ST_XY:   state_d = stat_i.sum_esc ? ST_DONE : ST_UPD;
      ST_UPD:  state_d = ST_XX;
      ST_DONE: if (out_free_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o      = 1'b0;
    emit_o         = 1'b0;
    ctrl_o         = '0;
    ctrl_o.mul_sel = MUL_XX;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o   = 1'b1;
        ctrl_o.load = s_valid_i;
      end
      // limit check wins over the magnitude check
      ST_XX:   ctrl_o.set_esc = !stat_i.cnt_lim && stat_i.mag_esc;
      ST_YY: begin
        ctrl_o.cap_xx  = 1'b1;
        ctrl_o.mul_sel = MUL_YY;
      end
      ST_XY: begin
        ctrl_o.set_esc = stat_i.sum_esc;
        ctrl_o.cap_yy  = !stat_i.sum_esc;
        ctrl_o.mul_sel = MUL_XY;
      end
      ST_UPD:  ctrl_o.upd = 1'b1;
      ST_DONE: emit_o = out_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mandelbrot_escape_time_unit.sv =====
// Top level of the escape-time unit: config registers, result register.
// Depends on mbe_pkg, mbe_ctrl and mbe_dpath.
//
//   channel  dir  handshake                    payload
//   s_axis   in   s_axis_tvalid/s_axis_tready  row, column
//   m_axis   out  m_axis_tvalid/m_axis_tready  iteration_count, escaped, range_error
//   cfg      in   cfg_we_i (no wait)           cfg_addr_i, cfg_wdata_i
//
// Each iteration runs x*x, y*y, x*y and the update on the shared 32x32 multiplier.
// An item outside the image goes straight to its result without iterating; one item
// is in work at a time. The result register frees the input side while a result
// waits; a stalled output holds the next result back in the sequencer. Reset needs
// no clearing pass.
`default_nettype none

module mandelbrot_escape_time_unit #(
  parameter int unsigned COORD_BITS = mbe_pkg::COORD_BITS_DEF,
  parameter int unsigned WORD_BITS  = mbe_pkg::WORD_BITS_DEF,
  localparam int unsigned IN_W      = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [IN_W-1:0]               s_axis_tdata,   // row, column
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mbe_pkg::OUT_W-1:0]     m_axis_tdata,   // iteration_count, escaped, range_error
  input  logic                          cfg_we_i,
  input  logic [mbe_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import mbe_pkg::*;

  logic [SIZE_W-1:0] size_log2_q;
  logic [ITER_W-1:0] max_iter_q;
  logic [BAIL_W-1:0] bailout_q;

  logic              m_valid_q;
  logic [OUT_W-1:0]  m_data_q, m_data_d;
  logic              out_free, emit;
  dp_ctrl_t          dp_ctrl;
  dp_stat_t          dp_stat;
  logic [ITER_W-1:0] count;
  logic              escaped, range_err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_log2_q <= SIZE_LOG2_RST;
      max_iter_q  <= MAX_ITER_RST;
      bailout_q   <= BAILOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_SIZE_LOG2: size_log2_q <= cfg_wdata_i[SIZE_W-1:0];
        REG_MAX_ITER:  max_iter_q  <= cfg_wdata_i[ITER_W-1:0];
        REG_BAILOUT:   bailout_q   <= cfg_wdata_i[BAIL_W-1:0];
        default: ;
      endcase
    end
  end

  mbe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .out_free_i (out_free),
    .stat_i     (dp_stat),
    .s_ready_o  (s_axis_tready),
    .emit_o     (emit),
    .ctrl_o     (dp_ctrl)
  );

  mbe_dpath #(
    .COORD_BITS (COORD_BITS),
    .WORD_BITS  (WORD_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .ctrl_i      (dp_ctrl),
    .row_i       (s_axis_tdata[COORD_BITS-1:0]),
    .col_i       (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .size_log2_i (size_log2_q),
    .max_iter_i  (max_iter_q),
    .bailout_i   (bailout_q),
    .stat_o      (dp_stat),
    .count_o     (count),
    .escaped_o   (escaped),
    .range_err_o (range_err)
  );

  assign out_free = !m_valid_q || m_axis_tready;
  assign m_data_d = {{(OUT_W - ITER_W - 2){1'b0}}, range_err, escaped, count};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

// ===== rtl/core/mbe_checker.sv =====
// Port-level assertions for the escape-time unit, bound to the top level.
// Depends on mbe_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module mbe_checker #(
  parameter int unsigned COORD_BITS = mbe_pkg::COORD_BITS_DEF,
  localparam int unsigned IN_W      = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [IN_W-1:0]           s_axis_tdata,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [mbe_pkg::OUT_W-1:0] m_axis_tdata
);
  import mbe_pkg::*;

  logic in_acc, out_stall, in_flag, range_dirty;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  // input bits are only watched for being known while an item is offered and the unit is ready
  assign in_flag   = s_axis_tvalid && (^s_axis_tdata === 1'bx);
  // a range error carries count 0 and escaped 0
  assign range_dirty = m_axis_tvalid && m_axis_tdata[ITER_W+1] &&
                       (m_axis_tdata[ITER_W:0] != '0);

  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata))
  `ASSERT_PROP(a_busy_after_accept, clk_i, rst_ni, in_acc |=> !s_axis_tready)
  `ASSERT_NEVER(a_range_clean, clk_i, rst_ni, range_dirty)
  `ASSERT_NEVER(a_pad_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[OUT_W-1:ITER_W+2] != '0)
  `ASSERT_NEVER(a_in_known, clk_i, rst_ni, in_flag && s_axis_tready)

endmodule

bind mandelbrot_escape_time_unit mbe_checker #(.COORD_BITS(COORD_BITS)) u_mbe_checker (.*);

`default_nettype wire
